// File: design/cia_pkg.sv
package cia_pkg;

  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;

  localparam logic [3:0] REG_PRA  = 4'd0;
  localparam logic [3:0] REG_PRB  = 4'd1;
  localparam logic [3:0] REG_DDRA = 4'd2;
  localparam logic [3:0] REG_DDRB = 4'd3;
  localparam logic [3:0] REG_TALO = 4'd4;
  localparam logic [3:0] REG_TAHI = 4'd5;
  localparam logic [3:0] REG_TBLO = 4'd6;
  localparam logic [3:0] REG_TBHI = 4'd7;
  localparam logic [3:0] REG_TOD0 = 4'd8;
  localparam logic [3:0] REG_TOD3 = 4'd11;
  localparam logic [3:0] REG_SDR  = 4'd12;
  localparam logic [3:0] REG_ICR  = 4'd13;
  localparam logic [3:0] REG_CRA  = 4'd14;
  localparam logic [3:0] REG_CRB  = 4'd15;

  // control register bits
  localparam int CR_START   = 0;
  localparam int CR_PBON    = 1;
  localparam int CR_TOGGLE  = 2;
  localparam int CR_ONESHOT = 3;
  localparam int CR_LOAD    = 4;
  localparam int CRA_INMODE = 5;
  localparam int CRB_ALARM  = 7;
  localparam int ICR_SET    = 7;

  // timer b input modes
  localparam logic [1:0] TB_TICKS  = 2'd0;
  localparam logic [1:0] TB_CNT    = 2'd1;
  localparam logic [1:0] TB_TA     = 2'd2;
  localparam logic [1:0] TB_TA_CNT = 2'd3;

  // interrupt sources
  localparam int INT_TA   = 0;
  localparam int INT_TB   = 1;
  localparam int INT_FLAG = 4;
  localparam int INT_BITS = 5;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq_line;
    logic       strobe_pc;
    logic [7:0] port_a_drive;
    logic [7:0] port_a_direction;
    logic [7:0] port_b_drive;
    logic [7:0] port_b_direction;
    logic       timer_a_line;
    logic       timer_b_line;
  } result_t;

endpackage

// File: design/complex_interface_adapter_timers.sv
// Timer and interrupt core of a 6526-style interface adapter. Each request is a clock tick,
// a bus read or a bus write; its result (read byte, interrupt line, pc strobe, port latches
// and timer lines after the request) is registered into the head of a two-entry output
// buffer, or into its skid entry while the head waits. One request per cycle is sustained
// while the output is not stalled; the input stalls only when both entries are full.
// Time-of-day and serial registers only hold what is written; they do not count.
module complex_interface_adapter_timers
  import cia_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] command,
  input  logic [3:0] address,
  input  logic [7:0] write_data,
  input  logic       read_side_effect,
  input  logic [7:0] port_a_in,
  input  logic [7:0] port_b_in,
  input  logic       cnt_pin,
  input  logic       flag_pin,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] read_data,
  output logic       irq_line,
  output logic       strobe_pc,
  output logic [7:0] port_a_drive,
  output logic [7:0] port_a_direction,
  output logic [7:0] port_b_drive,
  output logic [7:0] port_b_direction,
  output logic       timer_a_line,
  output logic       timer_b_line
);

  logic [7:0]          dir_a, dir_b, out_a, out_b;
  logic [15:0]         count_a, reload_a, count_b, reload_b;
  logic [7:0]          control_a, control_b;
  logic [INT_BITS-1:0] pending;
  logic                ir_flag;
  logic [INT_BITS-1:0] enable_mask;
  logic                line_a, line_b, pulse_hold_a, pulse_hold_b;
  logic [7:0]          clock_regs [4];
  logic [7:0]          serial_byte;
  logic                prev_cnt, prev_flag, pc_level, pc_hold;

  logic [7:0]          dir_a_next, dir_b_next, out_a_next, out_b_next;
  logic [15:0]         count_a_next, reload_a_next, count_b_next, reload_b_next;
  logic [7:0]          control_a_next, control_b_next;
  logic [INT_BITS-1:0] pending_next;
  logic                ir_flag_next;
  logic [INT_BITS-1:0] enable_mask_next;
  logic                line_a_next, line_b_next, pulse_hold_a_next, pulse_hold_b_next;
  logic [7:0]          clock_regs_next [4];
  logic [7:0]          serial_byte_next;
  logic                prev_cnt_next, prev_flag_next, pc_level_next, pc_hold_next;

  logic       accept, pop;
  logic       cnt_rise, ta_run, ta_under, tb_run, tb_under;
  logic [1:0] mode_b;
  logic [7:0] pb_value, rdata;
  result_t    result;

  logic    head_valid, skid_valid;
  result_t head, skid;

  assign in_stall = skid_valid;
  assign accept   = in_valid & ~skid_valid;
  assign pop      = head_valid & ~out_stall;

  assign cnt_rise = cnt_pin & ~prev_cnt;
  assign mode_b   = control_b[6:5];
  assign ta_run   = control_a[CR_START] & (~control_a[CRA_INMODE] | cnt_rise);
  assign ta_under = ta_run & (count_a == 16'd0);
  assign tb_run   = control_b[CR_START] &
                    ((mode_b == TB_TICKS) || (mode_b == TB_CNT && cnt_rise) ||
                     (ta_under && (mode_b == TB_TA || (mode_b == TB_TA_CNT && cnt_pin))));
  assign tb_under = tb_run & (count_b == 16'd0);

  always_comb begin
    pb_value = (out_b & dir_b) | (port_b_in & ~dir_b);
    if (control_a[CR_PBON]) begin
      pb_value[6] = line_a;
    end
    if (control_b[CR_PBON]) begin
      pb_value[7] = line_b;
    end
  end

  always_comb begin
    dir_a_next        = dir_a;
    dir_b_next        = dir_b;
    out_a_next        = out_a;
    out_b_next        = out_b;
    count_a_next      = count_a;
    reload_a_next     = reload_a;
    count_b_next      = count_b;
    reload_b_next     = reload_b;
    control_a_next    = control_a;
    control_b_next    = control_b;
    pending_next      = pending;
    ir_flag_next      = ir_flag;
    enable_mask_next  = enable_mask;
    line_a_next       = line_a;
    line_b_next       = line_b;
    pulse_hold_a_next = pulse_hold_a;
    pulse_hold_b_next = pulse_hold_b;
    clock_regs_next   = clock_regs;
    serial_byte_next  = serial_byte;
    prev_cnt_next     = prev_cnt;
    prev_flag_next    = prev_flag;
    pc_level_next     = pc_level;
    pc_hold_next      = pc_hold;
    rdata             = 8'h00;

    unique case (command)
      CMD_TICK: begin
        pc_level_next  = pc_level & pc_hold;
        pc_hold_next   = 1'b0;
        prev_flag_next = flag_pin;
        prev_cnt_next  = cnt_pin;
        if (prev_flag && !flag_pin) begin
          pending_next[INT_FLAG] = 1'b1;
        end
        // timer a
        if (ta_run) begin
          count_a_next = ta_under ? reload_a : count_a - 16'd1;
        end
        if (ta_under) begin
          pending_next[INT_TA] = 1'b1;
          if (control_a[CR_ONESHOT]) begin
            control_a_next[CR_START] = 1'b0;
          end
        end
        if (control_a[CR_TOGGLE]) begin
          line_a_next = line_a ^ ta_under;
        end else begin
          line_a_next       = ta_under | (line_a & pulse_hold_a);
          pulse_hold_a_next = 1'b0;
        end
        // timer b
        if (tb_run) begin
          count_b_next = tb_under ? reload_b : count_b - 16'd1;
        end
        if (tb_under) begin
          pending_next[INT_TB] = 1'b1;
          if (control_b[CR_ONESHOT]) begin
            control_b_next[CR_START] = 1'b0;
          end
        end
        if (control_b[CR_TOGGLE]) begin
          line_b_next = line_b ^ tb_under;
        end else begin
          line_b_next       = tb_under | (line_b & pulse_hold_b);
          pulse_hold_b_next = 1'b0;
        end
        if ((pending_next & enable_mask) != '0) begin
          ir_flag_next = 1'b1;
        end
      end
      CMD_READ: begin
        unique case (address) inside
          REG_PRA:  rdata = (out_a & dir_a) | (port_a_in & ~dir_a);
          REG_PRB: begin
            rdata = pb_value;
            if (read_side_effect) begin
              pc_level_next = 1'b1;
              pc_hold_next  = 1'b1;
            end
          end
          REG_DDRA: rdata = dir_a;
          REG_DDRB: rdata = dir_b;
          REG_TALO: rdata = count_a[7:0];
          REG_TAHI: rdata = count_a[15:8];
          REG_TBLO: rdata = count_b[7:0];
          REG_TBHI: rdata = count_b[15:8];
          [REG_TOD0:REG_TOD3]: rdata = clock_regs[address[1:0]];
          REG_SDR:  rdata = serial_byte;
          REG_ICR: begin
            rdata = {ir_flag, 2'b00, pending};
            if (read_side_effect) begin
              pending_next = '0;
              ir_flag_next = 1'b0;
            end
          end
          REG_CRA:  rdata = control_a;
          default:  rdata = control_b;
        endcase
      end
      CMD_WRITE: begin
        unique case (address) inside
          REG_PRA:  out_a_next = write_data;
          REG_PRB: begin
            out_b_next    = write_data;
            pc_level_next = 1'b1;
            pc_hold_next  = 1'b1;
          end
          REG_DDRA: dir_a_next = write_data;
          REG_DDRB: dir_b_next = write_data;
          REG_TALO: reload_a_next = {reload_a[15:8], write_data};
          REG_TAHI: reload_a_next = {write_data, reload_a[7:0]};
          REG_TBLO: reload_b_next = {reload_b[15:8], write_data};
          REG_TBHI: reload_b_next = {write_data, reload_b[7:0]};
          [REG_TOD0:REG_TOD3]: begin
            // writes with the alarm bit set are dropped; there is no alarm copy
            if (!control_b[CRB_ALARM]) begin
              clock_regs_next[address[1:0]] = write_data;
            end
          end
          REG_SDR:  serial_byte_next = write_data;
          REG_ICR: begin
            if (write_data[ICR_SET]) begin
              enable_mask_next = enable_mask | write_data[INT_BITS-1:0];
            end else begin
              enable_mask_next = enable_mask & ~write_data[INT_BITS-1:0];
            end
            if ((pending & enable_mask_next) != '0) begin
              ir_flag_next = 1'b1;
            end
          end
          REG_CRA: begin
            if (write_data[CR_LOAD]) begin
              count_a_next = reload_a;
            end
            control_a_next = {write_data[7:5], 1'b0, write_data[3:0]};
          end
          default: begin
            if (write_data[CR_LOAD]) begin
              count_b_next = reload_b;
            end
            control_b_next = {write_data[7:5], 1'b0, write_data[3:0]};
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    result.read_data        = rdata;
    result.irq_line         = ir_flag_next;
    result.strobe_pc        = pc_level_next;
    result.port_a_drive     = out_a_next;
    result.port_a_direction = dir_a_next;
    result.port_b_drive     = out_b_next;
    result.port_b_direction = dir_b_next;
    result.timer_a_line     = line_a_next;
    result.timer_b_line     = line_b_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dir_a        <= '0;
      dir_b        <= '0;
      out_a        <= '0;
      out_b        <= '0;
      count_a      <= '1;
      reload_a     <= '1;
      count_b      <= '1;
      reload_b     <= '1;
      control_a    <= '0;
      control_b    <= '0;
      pending      <= '0;
      ir_flag      <= 1'b0;
      enable_mask  <= '0;
      line_a       <= 1'b0;
      line_b       <= 1'b0;
      pulse_hold_a <= 1'b0;
      pulse_hold_b <= 1'b0;
      clock_regs   <= '{default: '0};
      serial_byte  <= '0;
      prev_cnt     <= 1'b0;
      prev_flag    <= 1'b1;
      pc_level     <= 1'b1;
      pc_hold      <= 1'b0;
    end else if (accept) begin
      dir_a        <= dir_a_next;
      dir_b        <= dir_b_next;
      out_a        <= out_a_next;
      out_b        <= out_b_next;
      count_a      <= count_a_next;
      reload_a     <= reload_a_next;
      count_b      <= count_b_next;
      reload_b     <= reload_b_next;
      control_a    <= control_a_next;
      control_b    <= control_b_next;
      pending      <= pending_next;
      ir_flag      <= ir_flag_next;
      enable_mask  <= enable_mask_next;
      line_a       <= line_a_next;
      line_b       <= line_b_next;
      pulse_hold_a <= pulse_hold_a_next;
      pulse_hold_b <= pulse_hold_b_next;
      clock_regs   <= clock_regs_next;
      serial_byte  <= serial_byte_next;
      prev_cnt     <= prev_cnt_next;
      prev_flag    <= prev_flag_next;
      pc_level     <= pc_level_next;
      pc_hold      <= pc_hold_next;
    end
  end

  // output buffer: head drives the ports, skid holds one more result
  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        head_valid <= accept;
      end
    end else if (head_valid) begin
      if (accept) begin
        skid_valid <= 1'b1;
      end
    end else begin
      head_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_valid) begin
        head <= skid;
      end else if (accept) begin
        head <= result;
      end
    end else if (head_valid) begin
      if (accept) begin
        skid <= result;
      end
    end else if (accept) begin
      head <= result;
    end
  end

  assign out_valid        = head_valid;
  assign read_data        = head.read_data;
  assign irq_line         = head.irq_line;
  assign strobe_pc        = head.strobe_pc;
  assign port_a_drive     = head.port_a_drive;
  assign port_a_direction = head.port_a_direction;
  assign port_b_drive     = head.port_b_drive;
  assign port_b_direction = head.port_b_direction;
  assign timer_a_line     = head.timer_a_line;
  assign timer_b_line     = head.timer_b_line;

endmodule

// File: design/cia_checker.sv
module cia_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] read_data,
  input logic       irq_line,
  input logic       strobe_pc
);

  // a held result keeps its value
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(read_data) && $stable(irq_line) &&
                               $stable(strobe_pc))
    else $error("held result changed");

  // input side stalls only with a result waiting
  assert property (@(posedge clk) disable iff (rst) !out_valid |-> !in_stall)
    else $error("stall with empty output");

  // a full buffer still shows a result next cycle
  assert property (@(posedge clk) disable iff (rst) in_stall |=> out_valid)
    else $error("buffered result lost");

  // reset empties the buffer
  assert property (@(posedge clk) rst |=> !out_valid && !in_stall)
    else $error("buffer not empty after reset");

endmodule

bind complex_interface_adapter_timers cia_checker u_checker (.*);

// File: dv/tb.sv
`timescale 1ns / 1ps

module tb;
  import cia_pkg::*;

  localparam int IRQ_SUMMARY = 5;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 8;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [1:0] command;
  logic [3:0] address;
  logic [7:0] write_data;
  logic       read_side_effect;
  logic [7:0] port_a_in;
  logic [7:0] port_b_in;
  logic       cnt_pin;
  logic       flag_pin;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] read_data;
  logic       irq_line;
  logic       strobe_pc;
  logic [7:0] port_a_drive;
  logic [7:0] port_a_direction;
  logic [7:0] port_b_drive;
  logic [7:0] port_b_direction;
  logic       timer_a_line;
  logic       timer_b_line;

  complex_interface_adapter_timers dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .command(command),
    .address(address),
    .write_data(write_data),
    .read_side_effect(read_side_effect),
    .port_a_in(port_a_in),
    .port_b_in(port_b_in),
    .cnt_pin(cnt_pin),
    .flag_pin(flag_pin),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .read_data(read_data),
    .irq_line(irq_line),
    .strobe_pc(strobe_pc),
    .port_a_drive(port_a_drive),
    .port_a_direction(port_a_direction),
    .port_b_drive(port_b_drive),
    .port_b_direction(port_b_direction),
    .timer_a_line(timer_a_line),
    .timer_b_line(timer_b_line)
  );

  // predicted adapter state
  logic [7:0]  ddr_a, ddr_b, pra_latch, prb_latch;
  logic [15:0] tmr_a_count, tmr_a_latch, tmr_b_count, tmr_b_latch;
  logic [7:0]  cra, crb;
  logic [5:0]  icr_flags;
  logic [4:0]  int_enable;
  logic        tmr_a_line, tmr_b_line, tmr_a_hold, tmr_b_hold;
  logic [7:0]  tod_clock [4];
  logic [7:0]  tod_alarm [4];
  logic [7:0]  sdr;
  logic        cnt_last, flag_last, pc_level, pc_armed;

  result_t expected_results [$];
  result_t oldest;
  int      error_count = 0;
  int      cycle_count = 0;
  int      stall_left = 0;
  bit      sender_idle;
  bit      receiver_idle;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic model_reset();
    ddr_a = 8'h00;
    ddr_b = 8'h00;
    pra_latch = 8'h00;
    prb_latch = 8'h00;
    tmr_a_count = 16'hFFFF;
    tmr_a_latch = 16'hFFFF;
    tmr_b_count = 16'hFFFF;
    tmr_b_latch = 16'hFFFF;
    cra = 8'h00;
    crb = 8'h00;
    icr_flags = '0;
    int_enable = '0;
    tmr_a_line = 1'b0;
    tmr_b_line = 1'b0;
    tmr_a_hold = 1'b0;
    tmr_b_hold = 1'b0;
    foreach (tod_clock[i]) begin
      tod_clock[i] = 8'h00;
      tod_alarm[i] = 8'h00;
    end
    sdr = 8'h00;
    cnt_last = 1'b0;
    flag_last = 1'b1;
    pc_level = 1'b1;
    pc_armed = 1'b0;
  endtask

  task automatic refresh_irq();
    if ((icr_flags[4:0] & int_enable) != 5'd0) icr_flags[IRQ_SUMMARY] = 1'b1;
  endtask

  task automatic count_timer_b();
    if (tmr_b_count == 16'd0) begin
      tmr_b_count = tmr_b_latch;
      if (crb[CR_TOGGLE]) begin
        tmr_b_line = ~tmr_b_line;
      end else begin
        tmr_b_line = 1'b1;
        tmr_b_hold = 1'b1;
      end
      icr_flags[INT_TB] = 1'b1;
      if (crb[CR_ONESHOT]) crb[CR_START] = 1'b0;
    end else begin
      tmr_b_count = tmr_b_count - 16'd1;
    end
  endtask

  task automatic count_timer_a(input logic cnt);
    if (tmr_a_count == 16'd0) begin
      tmr_a_count = tmr_a_latch;
      if (cra[CR_TOGGLE]) begin
        tmr_a_line = ~tmr_a_line;
      end else begin
        tmr_a_line = 1'b1;
        tmr_a_hold = 1'b1;
      end
      icr_flags[INT_TA] = 1'b1;
      if (cra[CR_ONESHOT]) cra[CR_START] = 1'b0;
      // cascade into timer b
      if (crb[CR_START] && (crb[6:5] == TB_TA || (crb[6:5] == TB_TA_CNT && cnt)))
        count_timer_b();
    end else begin
      tmr_a_count = tmr_a_count - 16'd1;
    end
  endtask

  task automatic model_tick(input logic cnt, input logic flag);
    logic rise;
    pc_level = pc_level & pc_armed;
    pc_armed = 1'b0;
    if (flag_last && !flag) icr_flags[INT_FLAG] = 1'b1;
    flag_last = flag;
    rise = cnt && !cnt_last;
    cnt_last = cnt;
    if (cra[CR_START] && (!cra[CRA_INMODE] || rise)) count_timer_a(cnt);
    if (crb[CR_START] && (crb[6:5] == TB_TICKS || (crb[6:5] == TB_CNT && rise)))
      count_timer_b();
    if (!cra[CR_TOGGLE]) begin
      tmr_a_line = tmr_a_line & tmr_a_hold;
      tmr_a_hold = 1'b0;
    end
    if (!crb[CR_TOGGLE]) begin
      tmr_b_line = tmr_b_line & tmr_b_hold;
      tmr_b_hold = 1'b0;
    end
    refresh_irq();
  endtask

  task automatic model_read(input logic [3:0] addr, input logic eff, input logic [7:0] pa,
                            input logic [7:0] pb, output logic [7:0] value);
    case (addr)
      REG_PRA: value = (pra_latch & ddr_a) | (pa & ~ddr_a);
      REG_PRB: begin
        value = (prb_latch & ddr_b) | (pb & ~ddr_b);
        if (cra[CR_PBON]) value[6] = tmr_a_line;
        if (crb[CR_PBON]) value[7] = tmr_b_line;
        if (eff) begin
          pc_level = 1'b1;
          pc_armed = 1'b1;
        end
      end
      REG_DDRA: value = ddr_a;
      REG_DDRB: value = ddr_b;
      REG_TALO: value = tmr_a_count[7:0];
      REG_TAHI: value = tmr_a_count[15:8];
      REG_TBLO: value = tmr_b_count[7:0];
      REG_TBHI: value = tmr_b_count[15:8];
      REG_SDR:  value = sdr;
      REG_ICR: begin
        value = {icr_flags[IRQ_SUMMARY], 2'b00, icr_flags[4:0]};
        if (eff) icr_flags = '0;
      end
      REG_CRA:  value = cra;
      REG_CRB:  value = crb;
      // time of day always reads the clock copy
      default:  value = tod_clock[addr[1:0]];
    endcase
  endtask

  task automatic model_write(input logic [3:0] addr, input logic [7:0] data);
    case (addr)
      REG_PRA: pra_latch = data;
      REG_PRB: begin
        prb_latch = data;
        pc_level = 1'b1;
        pc_armed = 1'b1;
      end
      REG_DDRA: ddr_a = data;
      REG_DDRB: ddr_b = data;
      REG_TALO: tmr_a_latch[7:0] = data;
      REG_TAHI: tmr_a_latch[15:8] = data;
      REG_TBLO: tmr_b_latch[7:0] = data;
      REG_TBHI: tmr_b_latch[15:8] = data;
      REG_SDR:  sdr = data;
      REG_ICR: begin
        if (data[ICR_SET]) int_enable = int_enable | data[4:0];
        else int_enable = int_enable & ~data[4:0];
        refresh_irq();
      end
      REG_CRA: begin
        if (data[CR_LOAD]) tmr_a_count = tmr_a_latch;
        cra = data;
        cra[CR_LOAD] = 1'b0;
      end
      REG_CRB: begin
        if (data[CR_LOAD]) tmr_b_count = tmr_b_latch;
        crb = data;
        crb[CR_LOAD] = 1'b0;
      end
      default: begin
        if (crb[CRB_ALARM]) tod_alarm[addr[1:0]] = data;
        else tod_clock[addr[1:0]] = data;
      end
    endcase
  endtask

  task automatic predict_result(input logic [1:0] cmd, input logic [3:0] addr,
                                input logic [7:0] data, input logic eff,
                                input logic [7:0] pa, input logic [7:0] pb,
                                input logic cnt, input logic flag, output result_t r);
    logic [7:0] rd;
    rd = 8'h00;
    case (cmd)
      CMD_TICK:  model_tick(cnt, flag);
      CMD_READ:  model_read(addr, eff, pa, pb, rd);
      CMD_WRITE: model_write(addr, data);
      default: ;
    endcase
    r.read_data = rd;
    r.irq_line = icr_flags[IRQ_SUMMARY];
    r.strobe_pc = pc_level;
    r.port_a_drive = pra_latch;
    r.port_a_direction = ddr_a;
    r.port_b_drive = prb_latch;
    r.port_b_direction = ddr_b;
    r.timer_a_line = tmr_a_line;
    r.timer_b_line = tmr_b_line;
  endtask

  task automatic send_request(input logic [1:0] cmd, input logic [3:0] addr,
                              input logic [7:0] data, input logic eff,
                              input logic [7:0] pa, input logic [7:0] pb,
                              input logic cnt, input logic flag);
    result_t r;
    int gap;
    gap = 0;
    if (sender_idle && $urandom_range(0, 7) == 0) gap = $urandom_range(1, 14);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    command <= cmd;
    address <= addr;
    write_data <= data;
    read_side_effect <= eff;
    port_a_in <= pa;
    port_b_in <= pb;
    cnt_pin <= cnt;
    flag_pin <= flag;
    do @(posedge clk); while (in_stall !== 1'b0);
    predict_result(cmd, addr, data, eff, pa, pb, cnt, flag, r);
    expected_results.push_back(r);
  endtask

  task automatic do_tick(input logic cnt, input logic flag);
    send_request(CMD_TICK, 4'($urandom), 8'($urandom), 1'($urandom), 8'($urandom),
                 8'($urandom), cnt, flag);
  endtask

  task automatic do_read(input logic [3:0] addr, input logic eff);
    send_request(CMD_READ, addr, 8'($urandom), eff, 8'($urandom), 8'($urandom),
                 1'($urandom), 1'($urandom));
  endtask

  task automatic do_write(input logic [3:0] addr, input logic [7:0] data);
    send_request(CMD_WRITE, addr, data, 1'($urandom), 8'($urandom), 8'($urandom),
                 1'($urandom), 1'($urandom));
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] latch_byte(input bit high);
    if ($urandom_range(0, 7) == 0) return 8'($urandom);
    return high ? 8'h00 : 8'($urandom_range(0, 6));
  endfunction

  // timers programmed with short counts, then a burst of ticks, reads and writes
  task automatic run_timer_sequence();
    logic [7:0] ctrl;
    int steps;
    int pick;
    do_write(REG_TALO, latch_byte(1'b0));
    do_write(REG_TAHI, latch_byte(1'b1));
    do_write(REG_TBLO, latch_byte(1'b0));
    do_write(REG_TBHI, latch_byte(1'b1));
    do_write(REG_ICR, 8'($urandom));
    ctrl = 8'($urandom);
    ctrl[CR_START] = ($urandom_range(0, 3) != 0);
    do_write(REG_CRA, ctrl);
    ctrl = 8'($urandom);
    ctrl[CR_START] = ($urandom_range(0, 3) != 0);
    do_write(REG_CRB, ctrl);
    steps = $urandom_range(8, 20);
    repeat (steps) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) do_tick(1'($urandom), $urandom_range(0, 3) != 0);
      else if (pick < 8) do_read(4'($urandom), 1'($urandom));
      else do_write(4'($urandom), 8'($urandom));
    end
  endtask

  task automatic test_register_access();
    do_read(REG_TAHI, 1'b0);
    do_read(REG_TBLO, 1'b1);
    do_write(REG_DDRA, 8'hFF);
    do_write(REG_PRA, 8'h00);
    send_request(CMD_READ, REG_PRA, 8'h00, 1'b1, 8'hFF, 8'h00, 1'b0, 1'b1);
    do_write(REG_DDRA, 8'h0F);
    do_write(REG_PRA, 8'hA5);
    send_request(CMD_READ, REG_PRA, 8'hFF, 1'b0, 8'hFF, 8'hFF, 1'b1, 1'b1);
    do_write(REG_DDRB, 8'hF0);
    do_write(REG_PRB, 8'hFF);
    do_write(REG_TOD0, 8'h12);
    do_write(REG_SDR, 8'hFF);
    do_read(REG_TOD0, 1'b1);
    do_read(REG_SDR, 1'b0);
  endtask

  task automatic test_timer_underflow();
    do_write(REG_ICR, 8'h9F);
    do_write(REG_TALO, 8'h01);
    do_write(REG_TAHI, 8'h00);
    do_write(REG_TBLO, 8'h00);
    do_write(REG_TBHI, 8'h00);
    // timer b toggles on each timer a underflow, timer a pulses once
    do_write(REG_CRB, {1'b0, TB_TA, 5'b10111});
    do_write(REG_CRA, 8'h1B);
    do_tick(1'b0, 1'b1);
    do_tick(1'b1, 1'b0);
    do_tick(1'b0, 1'b1);
    do_read(REG_PRB, 1'b1);
    do_tick(1'b1, 1'b1);
    do_read(REG_ICR, 1'b1);
    do_read(REG_CRA, 1'b0);
  endtask

  task automatic test_random_timers();
    for (int seq = 0; seq < 25; seq++) begin
      run_timer_sequence();
      if (seq == 15) wait_drained();
    end
  endtask

  task automatic test_random_noise();
    repeat (80)
      send_request(2'($urandom_range(0, 2)), 4'($urandom), 8'($urandom), 1'($urandom),
                   8'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
  endtask

  task automatic test_quiet_tail();
    sender_idle = 1'b0;
    receiver_idle = 1'b0;
    repeat (6) run_timer_sequence();
  endtask

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= 1'b0;
      if (receiver_idle && $urandom_range(0, 9) == 0) stall_left <= $urandom_range(1, 14);
    end
  end

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result expected none actual read_data %0h", $time, read_data);
        error_count++;
      end else begin
        oldest = expected_results.pop_front();
        check_field("read_data", oldest.read_data, read_data);
        check_field("irq_line", 8'(oldest.irq_line), 8'(irq_line));
        check_field("strobe_pc", 8'(oldest.strobe_pc), 8'(strobe_pc));
        check_field("port_a_drive", oldest.port_a_drive, port_a_drive);
        check_field("port_a_direction", oldest.port_a_direction, port_a_direction);
        check_field("port_b_drive", oldest.port_b_drive, port_b_drive);
        check_field("port_b_direction", oldest.port_b_direction, port_b_direction);
        check_field("timer_a_line", 8'(oldest.timer_a_line), 8'(timer_a_line));
        check_field("timer_b_line", 8'(oldest.timer_b_line), 8'(timer_b_line));
      end
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    command = CMD_TICK;
    address = REG_PRA;
    write_data = 8'h00;
    read_side_effect = 1'b0;
    port_a_in = 8'h00;
    port_b_in = 8'h00;
    cnt_pin = 1'b0;
    flag_pin = 1'b1;
    sender_idle = 1'b1;
    receiver_idle = 1'b1;
    model_reset();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_register_access();
    test_timer_underflow();
    test_random_timers();
    test_random_noise();
    test_quiet_tail();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
